### hw/rtl/anb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_pkg: shared types and constants of the Annex B NAL unit splitter
// Result record, start code and header field constants, header decode.
// ----------------------------------------------------------------------------
package anb_pkg;

  localparam int OFFSET_W = 24;
  localparam int LENGTH_W = 25;
  localparam int TYPE_W   = 5;
  localparam int IDC_W    = 2;

  localparam logic [7:0] ZERO_BYTE       = 8'h00;
  localparam logic [7:0] START_CODE_BYTE = 8'h01;

  localparam logic [7:0] HDR_FORBIDDEN_MASK = 8'h80;
  localparam logic [7:0] HDR_IDC_MASK       = 8'h60;
  localparam logic [7:0] HDR_TYPE_MASK      = 8'h1f;

  localparam logic [TYPE_W-1:0] NAL_TYPE_IDR = 5'd5;
  localparam logic [TYPE_W-1:0] NAL_TYPE_SPS = 5'd7;
  localparam logic [TYPE_W-1:0] NAL_TYPE_PPS = 5'd8;

  typedef struct packed {
    logic [OFFSET_W-1:0] nal_offset;
    logic [LENGTH_W-1:0] nal_length;
    logic [TYPE_W-1:0]   nal_type;
    logic [IDC_W-1:0]    ref_idc;
    logic                forbidden_bit;
    logic                key_frame;
    logic                empty_nal_error;
    logic                last_in_buffer;
  } result_t;

  function automatic logic is_key_type(input logic [TYPE_W-1:0] t);
    is_key_type = (t == NAL_TYPE_IDR) || (t == NAL_TYPE_SPS) || (t == NAL_TYPE_PPS);
  endfunction

  function automatic result_t decode_nal(input logic [7:0]          hdr,
                                         input logic [OFFSET_W-1:0] offset,
                                         input logic [LENGTH_W-1:0] length,
                                         input logic                last);
    result_t r;
    logic [7:0] t_bits;
    logic [7:0] i_bits;
    logic [7:0] f_bits;
    t_bits = hdr & HDR_TYPE_MASK;
    i_bits = (hdr & HDR_IDC_MASK) >> 5;
    f_bits = (hdr & HDR_FORBIDDEN_MASK) >> 7;
    r.nal_offset      = offset;
    r.nal_length      = length;
    r.nal_type        = t_bits[TYPE_W-1:0];
    r.ref_idc         = i_bits[IDC_W-1:0];
    r.forbidden_bit   = f_bits[0];
    r.key_frame       = is_key_type(t_bits[TYPE_W-1:0]);
    r.empty_nal_error = 1'b0;
    r.last_in_buffer  = last;
    decode_nal = r;
  endfunction

endpackage

### hw/rtl/anb_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anb_scan: per-byte start code scanner
// Holds the parse state and decides, for one byte, the state update and
// whether a NAL unit closes on it.
// ----------------------------------------------------------------------------
module anb_scan #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  output logic              res_valid,
  output anb_pkg::result_t  res
);

  localparam int PW = POSITION_WIDTH;
  localparam int OW = (PW > anb_pkg::OFFSET_W) ? PW : anb_pkg::OFFSET_W;
  localparam int EW = (PW + 1 > anb_pkg::LENGTH_W) ? PW + 1 : anb_pkg::LENGTH_W;
  localparam logic [PW:0] WRAP = {1'b1, {PW{1'b0}}};

  logic [PW-1:0] pos_r,   pos_nxt;
  logic [1:0]    zr_r,    zr_nxt;
  logic          open_r,  open_nxt;
  logic          seen_r,  seen_nxt;
  logic [PW-1:0] cs_r,    cs_nxt;
  logic [7:0]    hdr_r,   hdr_nxt;
  logic          hp_r,    hp_nxt;
  logic          halt_r,  halt_nxt;

  logic [PW:0]   next_pos;
  logic [PW:0]   cs_ext;
  logic [PW:0]   sub_len;
  logic [PW:0]   end_pos;
  logic [PW:0]   close_len;
  logic [PW:0]   flush_diff;
  logic [PW:0]   flush_len;
  logic [OW-1:0] cs_wide;
  logic [EW-1:0] close_wide;
  logic [EW-1:0] flush_wide;
  logic          start_code;
  logic          empty_hit;
  logic          clear;

  assign next_pos   = {1'b0, pos_r} + (PW+1)'(1);
  assign cs_ext     = {1'b0, cs_r};
  assign sub_len    = (zr_r == 2'd2) ? (PW+1)'(3) : (PW+1)'(4);
  assign end_pos    = (next_pos >= sub_len) ? next_pos - sub_len : '0;
  assign close_len  = end_pos - cs_ext;
  assign flush_diff = next_pos - cs_ext;
  // wrapped position: length runs through the top of the position range
  assign flush_len  = (next_pos >= cs_ext) ? flush_diff : flush_diff + WRAP;
  assign cs_wide    = OW'(cs_r);
  assign close_wide = EW'(close_len);
  assign flush_wide = EW'(flush_len);

  assign start_code = (data_byte == anb_pkg::START_CODE_BYTE) && (zr_r >= 2'd2);
  assign empty_hit  = start_code && seen_r && (end_pos <= cs_ext);

  always_comb begin
    pos_nxt   = pos_r;
    zr_nxt    = zr_r;
    open_nxt  = open_r;
    seen_nxt  = seen_r;
    cs_nxt    = cs_r;
    hdr_nxt   = hdr_r;
    hp_nxt    = hp_r;
    halt_nxt  = halt_r;
    res_valid = 1'b0;
    res       = '0;
    clear     = 1'b0;

    if (step) begin
      if (halt_r) begin
        clear = end_of_buffer;
      end else begin
        if (hp_r) begin
          hdr_nxt  = data_byte;
          hp_nxt   = 1'b0;
          open_nxt = 1'b1;
        end

        if (data_byte == anb_pkg::ZERO_BYTE) begin
          if (zr_r != 2'd3) begin
            zr_nxt = zr_r + 2'd1;
          end
        end else if (start_code) begin
          if (empty_hit) begin
            res_valid           = 1'b1;
            res.nal_offset      = cs_wide[anb_pkg::OFFSET_W-1:0];
            res.empty_nal_error = 1'b1;
            halt_nxt            = 1'b1;
            clear               = end_of_buffer;
          end else begin
            if (seen_r) begin
              res_valid = 1'b1;
              res = anb_pkg::decode_nal(hdr_nxt, cs_wide[anb_pkg::OFFSET_W-1:0],
                                        close_wide[anb_pkg::LENGTH_W-1:0], 1'b0);
            end
            seen_nxt = 1'b1;
            cs_nxt   = next_pos[PW-1:0];
            hp_nxt   = 1'b1;
            open_nxt = 1'b0;
            zr_nxt   = 2'd0;
          end
        end else begin
          zr_nxt = 2'd0;
        end

        if (!empty_hit) begin
          if (end_of_buffer) begin
            if (open_nxt && !res_valid) begin
              res_valid = 1'b1;
              res = anb_pkg::decode_nal(hdr_nxt, cs_wide[anb_pkg::OFFSET_W-1:0],
                                        flush_wide[anb_pkg::LENGTH_W-1:0], 1'b1);
            end
            clear = 1'b1;
          end else begin
            pos_nxt = next_pos[PW-1:0];
          end
        end
      end
    end

    if (clear) begin
      pos_nxt  = '0;
      zr_nxt   = 2'd0;
      open_nxt = 1'b0;
      seen_nxt = 1'b0;
      cs_nxt   = '0;
      hdr_nxt  = 8'h00;
      hp_nxt   = 1'b1;
      halt_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      zr_r   <= 2'd0;
      open_r <= 1'b0;
      seen_r <= 1'b0;
      cs_r   <= '0;
      hdr_r  <= 8'h00;
      hp_r   <= 1'b1;
      halt_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      zr_r   <= zr_nxt;
      open_r <= open_nxt;
      seen_r <= seen_nxt;
      cs_r   <= cs_nxt;
      hdr_r  <= hdr_nxt;
      hp_r   <= hp_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

### hw/rtl/annexb_nal_unit_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter: H.264 Annex B byte stream to NAL unit records
// Record path: the beat that closes a NAL (start code byte or end of buffer
//   byte) passes the input stage register, the scan, then the result register (out_valid).
// Throughput: 1 byte per cycle while the result register is free or being drained;
//   each byte is scanned through the zero-run counter and position compare in anb_scan.
// Reset: synchronous, rst_n low; both stages empty, parse state as at the
//   start of a buffer (the next byte is taken as a header byte).
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter #(
  parameter int POSITION_WIDTH = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_end_of_buffer,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [anb_pkg::OFFSET_W-1:0]       out_nal_offset,
  output logic [anb_pkg::LENGTH_W-1:0]       out_nal_length,
  output logic [anb_pkg::TYPE_W-1:0]         out_nal_type,
  output logic [anb_pkg::IDC_W-1:0]          out_ref_idc,
  output logic                               out_forbidden_bit,
  output logic                               out_key_frame,
  output logic                               out_empty_nal_error,
  output logic                               out_last_in_buffer
);

  // Input stage: one byte beat held in a register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_eob_r;

  // Result stage: one NAL record waiting for the consumer
  logic              out_valid_r;
  anb_pkg::result_t  out_res_r;

  logic              adv;
  logic              step;
  logic              res_valid;
  anb_pkg::result_t  res;

  // Advance the scan stage whenever the result register is free or being drained.
  // A byte that closes no NAL still advances, leaving the result register empty.
  assign adv      = !out_valid_r || out_ready;
  assign step     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // Payload: load on an accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_eob_r  <= in_end_of_buffer;
    end
  end

  anb_scan #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (s1_byte_r),
    .end_of_buffer (s1_eob_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= step && res_valid;
    end
  end

  // Hold the record until taken; load only when the scan produces one
  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_nal_offset      = out_res_r.nal_offset;
  assign out_nal_length      = out_res_r.nal_length;
  assign out_nal_type        = out_res_r.nal_type;
  assign out_ref_idc         = out_res_r.ref_idc;
  assign out_forbidden_bit   = out_res_r.forbidden_bit;
  assign out_key_frame       = out_res_r.key_frame;
  assign out_empty_nal_error = out_res_r.empty_nal_error;
  assign out_last_in_buffer  = out_res_r.last_in_buffer;

  // An empty NAL record carries no length, no header and no end-of-buffer mark
  a_empty_record : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_nal_error |->
      out_nal_length == '0 && !out_last_in_buffer && out_nal_type == '0)
    else $error("empty NAL record carries non-zero fields");

  // Key-frame flag must agree with the decoded type
  a_key_frame : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_frame == anb_pkg::is_key_type(out_nal_type))
    else $error("key frame flag disagrees with NAL type");

  // A byte held in the input stage during a stall must not move or be lost
  a_stage_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_byte_r) && $stable(s1_eob_r))
    else $error("input stage lost or changed a stalled byte");

endmodule
